FILE: rtl/core/cqsm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the circular queue with search and maximum.
package cqsm_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int CAP_W         = 7;
    localparam int OCC_W         = 7;
    localparam int WORD_W        = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [2:0] OP_ENQ    = 3'd0;
    localparam logic [2:0] OP_DEQ    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_MAX    = 3'd4;
    localparam logic [2:0] OP_TRAV   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic                     found;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic consume;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       left_zero;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: rtl/core/cqsm_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences each request through the queue datapath.
module cqsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cqsm_pkg::dp_stat_t stat,
    output cqsm_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_STEP1  = 5'b00100,
        S_WALK   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pend_reg;
    logic   pend_next;

    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (stat.op) inside
                    cqsm_pkg::OP_DEQ, cqsm_pkg::OP_PEEK:
                        state_next = stat.empty ? S_FINISH : S_STEP1;
                    cqsm_pkg::OP_MAX, cqsm_pkg::OP_TRAV:
                        state_next = stat.empty ? S_FINISH : S_WALK;
                    cqsm_pkg::OP_SEARCH:
                        state_next = S_WALK;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_STEP1:
            begin
                cmd.step   = 1'b1;
                state_next = S_FINISH;
            end
            S_WALK:
            begin
                // A fetched word is taken once it can be used; traverse needs the output free.
                cmd.consume = pend_reg &&
                              ((stat.op != cqsm_pkg::OP_TRAV) || stat.out_free);
                cmd.step    = !stat.left_zero && (!pend_reg || cmd.consume);
                if (cmd.step)
                begin
                    pend_next = 1'b1;
                end
                else if (cmd.consume)
                begin
                    pend_next = 1'b0;
                end
                if (stat.left_zero && !pend_reg)
                begin
                    state_next = (stat.op == cqsm_pkg::OP_TRAV) ? S_IDLE : S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: rtl/core/cqsm_dp.sv
`timescale 1ns / 1ps
// Datapath: slot memory, queue pointers, walk unit, capacity register and output register.
module cqsm_dp #(
    parameter int DEPTH = cqsm_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cqsm_pkg::dp_cmd_t                  cmd,
    output cqsm_pkg::dp_stat_t                 stat,
    input  cqsm_pkg::in_item_t                 in_item,
    input  logic                               cfg_valid,
    input  logic [cqsm_pkg::CAP_W-1:0]         cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output cqsm_pkg::out_item_t                out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = cqsm_pkg::CAP_W;
    localparam int EW = (CW > KW) ? CW : KW;
    localparam int OW = cqsm_pkg::OCC_W;
    localparam int DW = cqsm_pkg::WORD_W;

    logic signed [DW-1:0] slot_mem [DEPTH];

    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [KW-1:0]        cap_reg;
    logic [2:0]           op_reg;
    logic signed [DW-1:0] key_reg;
    logic [AW-1:0]        rd_ptr_reg;
    logic [CW-1:0]        left_reg;
    logic signed [DW-1:0] rd_data_reg;
    logic signed [DW-1:0] best_reg;
    logic                 first_reg;
    logic                 hit_reg;
    logic                 out_valid_reg, out_valid_next;
    cqsm_pkg::out_item_t  out_item_reg, out_item_next;

    logic [EW-1:0]        cap_ext;
    logic [EW-1:0]        eff_cap;
    logic                 full;
    logic                 empty;
    logic                 out_free;
    logic                 wr_en;
    logic                 load_out;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    // A capacity of zero acts as one, and one above the built depth acts as the depth.
    assign cap_ext  = EW'(cap_reg);
    assign eff_cap  = (cap_reg == '0) ? EW'(1) :
                      ((cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext);
    assign full     = EW'(count_reg) >= eff_cap;
    assign empty    = (count_reg == '0);
    assign out_free = !out_valid_reg || !out_stall;
    assign wr_en    = cmd.finish && (op_reg == cqsm_pkg::OP_ENQ) && !full;

    assign stat.op        = op_reg;
    assign stat.empty     = empty;
    assign stat.left_zero = (left_reg == '0);
    assign stat.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[tail_reg] <= key_reg;
        end
        if (cmd.step)
        begin
            rd_data_reg <= slot_mem[rd_ptr_reg];
        end
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        out_item_next = out_item_reg;
        load_out      = 1'b0;

        if (cmd.finish)
        begin
            load_out               = 1'b1;
            out_item_next.data     = '0;
            out_item_next.found    = 1'b0;
            out_item_next.status   = cqsm_pkg::ST_OK;
            out_item_next.last     = 1'b1;
            unique case (op_reg)
                cqsm_pkg::OP_ENQ:
                begin
                    if (full)
                    begin
                        out_item_next.status = cqsm_pkg::ST_OVF;
                    end
                    else
                    begin
                        tail_next  = inc_ptr(tail_reg);
                        count_next = CW'(count_reg + 1'b1);
                    end
                end
                cqsm_pkg::OP_DEQ:
                begin
                    if (empty)
                    begin
                        out_item_next.status = cqsm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_item_next.data = rd_data_reg;
                        head_next          = inc_ptr(head_reg);
                        count_next         = CW'(count_reg - 1'b1);
                    end
                end
                cqsm_pkg::OP_PEEK:
                begin
                    if (empty)
                    begin
                        out_item_next.status = cqsm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_item_next.data = rd_data_reg;
                    end
                end
                cqsm_pkg::OP_SEARCH:
                begin
                    out_item_next.found = hit_reg;
                end
                cqsm_pkg::OP_MAX:
                begin
                    if (empty)
                    begin
                        out_item_next.status = cqsm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_item_next.data = best_reg;
                    end
                end
                cqsm_pkg::OP_TRAV:
                begin
                    // Only an empty traverse finishes here; a non-empty one emits while walking.
                    out_item_next.status = cqsm_pkg::ST_EMPTY;
                end
                default:
                begin
                end
            endcase
            out_item_next.occupancy = OW'(count_next);
        end
        else if (cmd.consume && (op_reg == cqsm_pkg::OP_TRAV))
        begin
            load_out                = 1'b1;
            out_item_next.data      = rd_data_reg;
            out_item_next.found     = 1'b0;
            out_item_next.status    = cqsm_pkg::ST_OK;
            out_item_next.occupancy = OW'(count_reg);
            out_item_next.last      = (left_reg == '0);
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= cqsm_pkg::CAP_RESET;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                left_reg <= count_reg;
            end
            else if (cmd.step)
            begin
                left_reg <= CW'(left_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= in_item.op;
            key_reg    <= in_item.value;
            rd_ptr_reg <= head_reg;
            first_reg  <= 1'b1;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                rd_ptr_reg <= inc_ptr(rd_ptr_reg);
            end
            if (cmd.consume)
            begin
                first_reg <= 1'b0;
                if (rd_data_reg == key_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (first_reg || (rd_data_reg > best_reg))
                begin
                    best_reg <= rd_data_reg;
                end
            end
        end
        if (load_out)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/core/circular_queue_with_search_max.sv
`timescale 1ns / 1ps
// Top level of the circular queue with search, maximum and traverse requests.
// The block takes one request at a time. After acceptance the controller decides in
// S_DECIDE: enqueue, the unused codes and dequeue, peek, max or traverse on an empty queue
// go straight to S_FINISH, which loads the result into the output register; dequeue and
// peek read the head slot in S_STEP1 first; search and max walk the stored words in S_WALK
// before S_FINISH, and traverse loads each of its results from S_WALK. The walk rate is
// set by the single read port of the slot memory, which yields one word per cycle while a
// traverse's output is free; a stalled output holds a traverse walk. A result sits in an
// output register, so the next request is taken while it waits. Capacity writes are always
// accepted and must be made while the queue is idle.
module circular_queue_with_search_max #(
    parameter int DEPTH = cqsm_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cqsm_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cqsm_pkg::out_item_t         out_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cqsm_pkg::CAP_W-1:0]  cfg_data
);

    cqsm_pkg::dp_cmd_t  cmd;
    cqsm_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    cqsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cqsm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Only one request is in flight, so the input must stall right after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in progress");

    // The walk never fetches past the number of stored words.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !stat.left_zero)
        else $error("slot fetch issued past the end of the walk");

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish || (cmd.consume && (stat.op == cqsm_pkg::OP_TRAV))) |-> stat.out_free)
        else $error("result loaded into a busy output register");

endmodule

FILE: test/tb_circular_queue_with_search_max.sv
`timescale 1ns / 1ps
// Self-checking testbench for the circular queue with search, maximum and traverse requests.
module tb_circular_queue_with_search_max;

    localparam int SLOTS = cqsm_pkg::DEPTH_DEFAULT;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 80;

    typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic [2:0]          op;
        logic [31:0]         value;
        bit                  typed;
        cqsm_pkg::out_item_t want;
    } plan_row_t;

    typedef struct {
        int cap;
        int count;
        int enq_pct;
    } phase_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    cqsm_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall;
    cqsm_pkg::out_item_t out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [cqsm_pkg::CAP_W-1:0] cfg_data;

    // Shadow copy of the queue, advanced once per accepted request.
    logic signed [cqsm_pkg::WORD_W-1:0] slot_copy [SLOTS];
    int               head_copy;
    int               tail_copy;
    int               held;
    logic [cqsm_pkg::CAP_W-1:0] capacity_copy;

    cqsm_pkg::out_item_t step_results[$];
    cqsm_pkg::out_item_t awaited_results[$];
    cqsm_pkg::out_item_t want;

    int errors;
    int results_checked;
    int requests_sent;
    int capacity_writes;
    int burst_left;
    int peak_held;
    int overflow_seen;
    int empty_seen;
    int holds_asked;
    int holds_done;

    circular_queue_with_search_max #(
        .DEPTH(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("circular_queue_with_search_max verification failed");
        $finish;
    end

    function automatic cqsm_pkg::out_item_t make_result(logic [31:0] data, logic found,
                                                        logic [1:0] status, logic last);
        cqsm_pkg::out_item_t r;
        r.data      = data;
        r.found     = found;
        r.status    = status;
        r.occupancy = cqsm_pkg::OCC_W'(held);
        r.last      = last;
        return r;
    endfunction

    // Capacity 0 behaves as 1 and anything above the depth as the depth.
    function automatic int room();
        if (capacity_copy == 0)
            return 1;
        if (capacity_copy > SLOTS)
            return SLOTS;
        return capacity_copy;
    endfunction

    task automatic apply_request(cqsm_pkg::in_item_t it);
        int idx;
        logic signed [cqsm_pkg::WORD_W-1:0] best;
        logic hit;
        step_results.delete();
        idx = head_copy;
        hit = 1'b0;
        case (it.op)
            cqsm_pkg::OP_ENQ:
            begin
                if (held >= room())
                    step_results.push_back(make_result(0, 1'b0, cqsm_pkg::ST_OVF, 1'b1));
                else
                begin
                    slot_copy[tail_copy] = it.value;
                    tail_copy = (tail_copy + 1) % SLOTS;
                    held++;
                    step_results.push_back(make_result(0, 1'b0, cqsm_pkg::ST_OK, 1'b1));
                end
            end
            cqsm_pkg::OP_DEQ:
            begin
                if (held == 0)
                    step_results.push_back(make_result(0, 1'b0, cqsm_pkg::ST_EMPTY, 1'b1));
                else
                begin
                    best = slot_copy[head_copy];
                    head_copy = (head_copy + 1) % SLOTS;
                    held--;
                    step_results.push_back(make_result(best, 1'b0, cqsm_pkg::ST_OK, 1'b1));
                end
            end
            cqsm_pkg::OP_PEEK:
            begin
                if (held == 0)
                    step_results.push_back(make_result(0, 1'b0, cqsm_pkg::ST_EMPTY, 1'b1));
                else
                    step_results.push_back(make_result(slot_copy[head_copy], 1'b0,
                                                       cqsm_pkg::ST_OK, 1'b1));
            end
            cqsm_pkg::OP_SEARCH:
            begin
                for (int n = 0; n < held; n++)
                begin
                    if (slot_copy[idx] == it.value)
                        hit = 1'b1;
                    idx = (idx + 1) % SLOTS;
                end
                step_results.push_back(make_result(0, hit, cqsm_pkg::ST_OK, 1'b1));
            end
            cqsm_pkg::OP_MAX:
            begin
                if (held == 0)
                    step_results.push_back(make_result(0, 1'b0, cqsm_pkg::ST_EMPTY, 1'b1));
                else
                begin
                    best = slot_copy[idx];
                    for (int n = 1; n < held; n++)
                    begin
                        idx = (idx + 1) % SLOTS;
                        if (slot_copy[idx] > best)
                            best = slot_copy[idx];
                    end
                    step_results.push_back(make_result(best, 1'b0, cqsm_pkg::ST_OK, 1'b1));
                end
            end
            cqsm_pkg::OP_TRAV:
            begin
                if (held == 0)
                    step_results.push_back(make_result(0, 1'b0, cqsm_pkg::ST_EMPTY, 1'b1));
                for (int n = 0; n < held; n++)
                begin
                    step_results.push_back(make_result(slot_copy[idx], 1'b0, cqsm_pkg::ST_OK,
                                                       n == held - 1));
                    idx = (idx + 1) % SLOTS;
                end
            end
            default:
                step_results.push_back(make_result(0, 1'b0, cqsm_pkg::ST_OK, 1'b1));
        endcase
        if (held > peak_held)
            peak_held = held;
        foreach (step_results[k])
        begin
            if (step_results[k].status == cqsm_pkg::ST_OVF)
                overflow_seen++;
            if (step_results[k].status == cqsm_pkg::ST_EMPTY)
                empty_seen++;
        end
    endtask

    function automatic plan_row_t req(logic [2:0] op, logic [31:0] value);
        plan_row_t r;
        r.kind  = ROW_REQUEST;
        r.op    = op;
        r.value = value;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic plan_row_t req_exp(logic [2:0] op, logic [31:0] value,
                                          logic [31:0] data, logic found,
                                          logic [1:0] status, int occ);
        plan_row_t r;
        r = req(op, value);
        r.typed          = 1'b1;
        r.want.data      = data;
        r.want.found     = found;
        r.want.status    = status;
        r.want.occupancy = cqsm_pkg::OCC_W'(occ);
        r.want.last      = 1'b1;
        return r;
    endfunction

    function automatic plan_row_t set_cap(int v);
        plan_row_t r;
        r = req(cqsm_pkg::OP_ENQ, 32'(v));
        r.kind = ROW_CAPACITY;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 16) - 8;
            8:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_op(int enq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            return cqsm_pkg::OP_ENQ;
        r = $urandom_range(0, 99);
        if (r < 30)
            return cqsm_pkg::OP_DEQ;
        if (r < 45)
            return cqsm_pkg::OP_PEEK;
        if (r < 65)
            return cqsm_pkg::OP_SEARCH;
        if (r < 80)
            return cqsm_pkg::OP_MAX;
        if (r < 95)
            return cqsm_pkg::OP_TRAV;
        return (r < 97) ? OP_SPARE6 : OP_SPARE7;
    endfunction

    // Offers one request, opening a new burst after a random gap when the last one ran out.
    task automatic offer(cqsm_pkg::in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        requests_sent++;
    endtask

    task automatic issue(cqsm_pkg::in_item_t it);
        offer(it);
        apply_request(it);
        foreach (step_results[k])
            awaited_results.push_back(step_results[k]);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(int v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cqsm_pkg::CAP_W'(v);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        capacity_copy = cqsm_pkg::CAP_W'(v);
        capacity_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Output side: quiet stretches, random stalls, and a long hold-off when one is asked for.
    initial
    begin
        int quiet_left;
        int busy_left;
        quiet_left = 20;
        busy_left  = 0;
        holds_done = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_asked)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end
            else if (quiet_left > 0)
            begin
                out_stall <= 1'b0;
                quiet_left--;
            end
            else if (busy_left > 0)
            begin
                out_stall <= ($urandom_range(0, 99) < 35);
                busy_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 1) == 0)
                    quiet_left = $urandom_range(1, 40);
                else
                    busy_left = $urandom_range(5, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing awaited: data %0d status %0d occupancy %0d",
                       out_item.data, out_item.status, out_item.occupancy);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (out_item.data !== want.data)
                begin
                    $error("data: expected %0d, actual %0d", want.data, out_item.data);
                    errors++;
                end
                if (out_item.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, out_item.found);
                    errors++;
                end
                if (out_item.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_item.status);
                    errors++;
                end
                if (out_item.occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d", want.occupancy,
                           out_item.occupancy);
                    errors++;
                end
                if (out_item.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, out_item.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        plan_row_t          plan[$];
        phase_t             phases[5];
        plan_row_t          row;
        cqsm_pkg::in_item_t it;

        errors          = 0;
        results_checked = 0;
        requests_sent   = 0;
        capacity_writes = 0;
        burst_left      = 0;
        peak_held       = 0;
        overflow_seen   = 0;
        empty_seen      = 0;
        holds_asked     = 0;
        head_copy       = 0;
        tail_copy       = 0;
        held            = 0;
        capacity_copy   = cqsm_pkg::CAP_RESET;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;

        // Empty queue, unused codes, extremes, then capacity squeezed under the occupancy.
        plan.push_back(req_exp(cqsm_pkg::OP_DEQ, 32'd0, 32'd0, 1'b0, cqsm_pkg::ST_EMPTY, 0));
        plan.push_back(req_exp(cqsm_pkg::OP_PEEK, 32'd0, 32'd0, 1'b0, cqsm_pkg::ST_EMPTY, 0));
        plan.push_back(req_exp(cqsm_pkg::OP_MAX, 32'd0, 32'd0, 1'b0, cqsm_pkg::ST_EMPTY, 0));
        plan.push_back(req_exp(cqsm_pkg::OP_TRAV, 32'd0, 32'd0, 1'b0, cqsm_pkg::ST_EMPTY, 0));
        plan.push_back(req_exp(cqsm_pkg::OP_SEARCH, 32'd0, 32'd0, 1'b0, cqsm_pkg::ST_OK, 0));
        plan.push_back(req_exp(OP_SPARE6, 32'h1234_5678, 32'd0, 1'b0, cqsm_pkg::ST_OK, 0));
        plan.push_back(req_exp(OP_SPARE7, 32'hFFFF_FFFF, 32'd0, 1'b0, cqsm_pkg::ST_OK, 0));
        plan.push_back(req_exp(cqsm_pkg::OP_ENQ, 32'h8000_0000, 32'd0, 1'b0,
                               cqsm_pkg::ST_OK, 1));
        plan.push_back(req_exp(cqsm_pkg::OP_ENQ, 32'h7FFF_FFFF, 32'd0, 1'b0,
                               cqsm_pkg::ST_OK, 2));
        plan.push_back(req_exp(cqsm_pkg::OP_ENQ, 32'h0000_0000, 32'd0, 1'b0,
                               cqsm_pkg::ST_OK, 3));
        plan.push_back(req_exp(cqsm_pkg::OP_ENQ, 32'hFFFF_FFFF, 32'd0, 1'b0,
                               cqsm_pkg::ST_OK, 4));
        plan.push_back(req_exp(cqsm_pkg::OP_PEEK, 32'd0, 32'h8000_0000, 1'b0,
                               cqsm_pkg::ST_OK, 4));
        plan.push_back(req_exp(cqsm_pkg::OP_MAX, 32'd0, 32'h7FFF_FFFF, 1'b0,
                               cqsm_pkg::ST_OK, 4));
        plan.push_back(req_exp(cqsm_pkg::OP_SEARCH, 32'h7FFF_FFFF, 32'd0, 1'b1,
                               cqsm_pkg::ST_OK, 4));
        plan.push_back(req_exp(cqsm_pkg::OP_SEARCH, 32'd5, 32'd0, 1'b0, cqsm_pkg::ST_OK, 4));
        plan.push_back(req(cqsm_pkg::OP_TRAV, 32'd0));
        plan.push_back(req_exp(cqsm_pkg::OP_DEQ, 32'd0, 32'h8000_0000, 1'b0,
                               cqsm_pkg::ST_OK, 3));
        plan.push_back(set_cap(0));
        plan.push_back(req_exp(cqsm_pkg::OP_ENQ, 32'd123, 32'd0, 1'b0, cqsm_pkg::ST_OVF, 3));
        plan.push_back(req_exp(cqsm_pkg::OP_DEQ, 32'd0, 32'h7FFF_FFFF, 1'b0,
                               cqsm_pkg::ST_OK, 2));
        plan.push_back(req_exp(cqsm_pkg::OP_DEQ, 32'd0, 32'd0, 1'b0, cqsm_pkg::ST_OK, 1));
        plan.push_back(req_exp(cqsm_pkg::OP_ENQ, 32'd7, 32'd0, 1'b0, cqsm_pkg::ST_OVF, 1));
        plan.push_back(set_cap(127));
        plan.push_back(req(cqsm_pkg::OP_ENQ, 32'd7));
        plan.push_back(req(cqsm_pkg::OP_MAX, 32'd0));
        plan.push_back(req(cqsm_pkg::OP_TRAV, 32'd0));

        phases[0] = '{cap: 3, count: 35, enq_pct: 50};
        phases[1] = '{cap: SLOTS, count: 85, enq_pct: 80};
        phases[2] = '{cap: 100, count: 30, enq_pct: 30};
        phases[3] = '{cap: 1, count: 25, enq_pct: 50};
        phases[4] = '{cap: 17, count: 35, enq_pct: 55};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CAPACITY)
            begin
                wait_drained();
                write_capacity(row.value);
            end
            else
            begin
                it.op    = row.op;
                it.value = row.value;
                if (row.typed)
                begin
                    offer(it);
                    apply_request(it);
                    awaited_results.push_back(row.want);
                end
                else
                    issue(it);
            end
        end

        foreach (phases[p])
        begin
            wait_drained();
            write_capacity(phases[p].cap);
            // While the full-depth phase starts, the output is held off so the block backs up.
            if (phases[p].cap == SLOTS)
                holds_asked++;
            for (int k = 0; k < phases[p].count; k++)
            begin
                if (p == 1 && k == phases[p].count / 2)
                    wait_drained();
                it.op = pick_op(phases[p].enq_pct);
                if (it.op == cqsm_pkg::OP_SEARCH && held > 0 && $urandom_range(0, 1) == 1)
                    it.value = slot_copy[(head_copy + $urandom_range(0, held - 1)) % SLOTS];
                else
                    it.value = pick_value();
                issue(it);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d results over %0d capacity writes.",
                 requests_sent, results_checked, capacity_writes);
        $display("Peak occupancy %0d, %0d overflow and %0d empty-queue results, %0d hold-offs.",
                 peak_held, overflow_seen, empty_seen, holds_done);
        if (errors == 0)
            $display("circular_queue_with_search_max verification clean");
        else
            $display("circular_queue_with_search_max verification failed");
        $finish;
    end

endmodule

FILE: circular_queue_with_search_max.f
rtl/core/cqsm_pkg.sv
rtl/core/cqsm_ctrl.sv
rtl/core/cqsm_dp.sv
rtl/core/circular_queue_with_search_max.sv
test/tb_circular_queue_with_search_max.sv
